/* hw/rtl/swu_pkg.sv */
// Shared types, constants and tables of the sample warp unit.
// No dependencies; every other file of the block but swu_delay uses it.
package swu_pkg;

    localparam int OUT_W   = 24;            // output / vertex coordinate width
    localparam int SMP_W   = 16;            // sample width, Q0.16
    localparam int KIND_W  = 3;
    localparam int RAD_W   = 31;            // radicand / root width, Q.30 in [0,1]
    localparam int SQ_LAT  = RAD_W;         // one root bit per stage
    localparam int ANG_W   = 33;            // CORDIC word, signed Q.30
    localparam int ATAN_N  = 24;

    localparam logic [KIND_W-1:0] KIND_HEMI   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPHERE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TRI    = 3'd4;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic [2:0][OUT_W-1:0]   vec_t;   // [0]=x [1]=y [2]=z
    typedef vec_t [2:0]              tri_t;   // three vertices

    localparam logic [RAD_W-1:0] ONE_U30    = 31'h4000_0000;
    localparam ang_t             ONE_Q30    = 33'sh0_4000_0000;
    localparam ang_t             GAIN_Q30   = 33'sd652032874;
    localparam logic [32:0]      TWO_PI_Q30 = 33'd6746518852;

    // arctan(2^-i) in Q.30 radians
    localparam ang_t ATAN_Q30 [ATAN_N] = '{
        33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
        33'sd67021688,  33'sd33543516,  33'sd16775851,  33'sd8388437,
        33'sd4194283,   33'sd2097149,   33'sd1048576,   33'sd524288,
        33'sd262144,    33'sd131072,    33'sd65536,     33'sd32768,
        33'sd16384,     33'sd8192,      33'sd4096,      33'sd2048,
        33'sd1024,      33'sd512,       33'sd256,       33'sd128
    };

    // Side data that travels with each beat down the pipeline
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [SMP_W-1:0]  u;
        logic [SMP_W-1:0]  v;
        ang_t              zf;     // z in Q.30 for kinds whose z is not a root
        tri_t              vtx;
    } side_t;

endpackage

/* hw/rtl/swu_in_if.sv */
// Input channel of the sample warp unit: valid/ready plus one sample beat.
// Depends on swu_pkg.
interface swu_in_if;
    logic                                valid;
    logic                                ready;
    logic [swu_pkg::KIND_W-1:0]          kind;
    logic [swu_pkg::SMP_W-1:0]           u_sample;
    logic [swu_pkg::SMP_W-1:0]           v_sample;
    logic signed [swu_pkg::OUT_W-1:0]    vertex0_x;
    logic signed [swu_pkg::OUT_W-1:0]    vertex0_y;
    logic signed [swu_pkg::OUT_W-1:0]    vertex0_z;
    logic signed [swu_pkg::OUT_W-1:0]    vertex1_x;
    logic signed [swu_pkg::OUT_W-1:0]    vertex1_y;
    logic signed [swu_pkg::OUT_W-1:0]    vertex1_z;
    logic signed [swu_pkg::OUT_W-1:0]    vertex2_x;
    logic signed [swu_pkg::OUT_W-1:0]    vertex2_y;
    logic signed [swu_pkg::OUT_W-1:0]    vertex2_z;

    modport source (
        output valid, kind, u_sample, v_sample,
        output vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
        output vertex2_x, vertex2_y, vertex2_z,
        input  ready
    );
    modport sink (
        input  valid, kind, u_sample, v_sample,
        input  vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
        input  vertex2_x, vertex2_y, vertex2_z,
        output ready
    );
endinterface

/* hw/rtl/swu_out_if.sv */
// Output channel of the sample warp unit: valid/ready plus one point beat.
// Depends on swu_pkg.
interface swu_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [swu_pkg::OUT_W-1:0] point_x;
    logic signed [swu_pkg::OUT_W-1:0] point_y;
    logic signed [swu_pkg::OUT_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

/* hw/rtl/swu_delay.sv */
// Stallable delay line used to keep side data aligned with the math pipes.
// No package dependency.
module swu_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

/* hw/rtl/swu_sqrt.sv */
// Pipelined floor square root of a Q.30 value, one root bit per stage.
// Depends on swu_pkg.
module swu_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [swu_pkg::RAD_W-1:0]   rad,
    output logic [swu_pkg::RAD_W-1:0]   root
);

    localparam int RW = swu_pkg::RAD_W + 3;     // partial remainder
    localparam int NW = 2 * swu_pkg::SQ_LAT;    // radicand << 30, even width
    localparam int LAT = swu_pkg::SQ_LAT;
    localparam int FB = NW - 1 - swu_pkg::RAD_W;

    logic [NW-1:0]                n_reg    [LAT];
    logic [RW-1:0]                rem_reg  [LAT];
    logic [swu_pkg::RAD_W-1:0]    root_reg [LAT];

    for (genvar k = 0; k < LAT; k++)
    begin : g_stage
        logic [NW-1:0]             n_in;
        logic [RW-1:0]             rem_in;
        logic [swu_pkg::RAD_W-1:0] root_in;
        logic [RW-1:0]             rem_sh;
        logic [RW-1:0]             trial;

        if (k == 0)
        begin : g_first
            assign n_in    = {1'b0, rad, {FB{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[swu_pkg::RAD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[swu_pkg::RAD_W-2:0], 1'b0};
                end
                n_reg[k] <= {n_in[NW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[LAT-1];

endmodule

/* hw/rtl/swu_cordic.sv */
// Pipelined rotation-mode CORDIC: cos/sin of a first-quadrant angle, then
// quadrant fold. Depends on swu_pkg.
module swu_cordic #(
    parameter int STAGES = 16
) (
    input  logic          clk,
    input  logic          en,
    input  swu_pkg::ang_t z_in,
    input  logic [1:0]    quad_in,
    output swu_pkg::ang_t cos_out,
    output swu_pkg::ang_t sin_out
);

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    swu_pkg::ang_t x_reg [STAGES];
    swu_pkg::ang_t y_reg [STAGES];
    swu_pkg::ang_t z_reg [STAGES];
    logic [1:0]    q_reg [STAGES];
    swu_pkg::ang_t cos_reg;
    swu_pkg::ang_t sin_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        swu_pkg::ang_t x_in;
        swu_pkg::ang_t y_in;
        swu_pkg::ang_t z_st;
        logic [1:0]    q_in;
        swu_pkg::ang_t dx;
        swu_pkg::ang_t dy;

        if (k == 0)
        begin : g_first
            assign x_in = swu_pkg::GAIN_Q30;
            assign y_in = '0;
            assign z_st = z_in;
            assign q_in = quad_in;
        end
        else
        begin : g_next
            assign x_in = x_reg[k-1];
            assign y_in = y_reg[k-1];
            assign z_st = z_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        assign dx = y_in >>> k;
        assign dy = x_in >>> k;

        // micro-rotation toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_st[swu_pkg::ANG_W-1])
                begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_st - swu_pkg::ATAN_Q30[k];
                end
                else
                begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_st + swu_pkg::ATAN_Q30[k];
                end
                q_reg[k] <= q_in;
            end
        end
    end

    // quadrant fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (q_reg[STAGES-1])
                QUAD_I:
                begin
                    cos_reg <= x_reg[STAGES-1];
                    sin_reg <= y_reg[STAGES-1];
                end
                QUAD_II:
                begin
                    cos_reg <= -y_reg[STAGES-1];
                    sin_reg <= x_reg[STAGES-1];
                end
                QUAD_III:
                begin
                    cos_reg <= -x_reg[STAGES-1];
                    sin_reg <= -y_reg[STAGES-1];
                end
                default:
                begin
                    cos_reg <= y_reg[STAGES-1];
                    sin_reg <= -x_reg[STAGES-1];
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

/* hw/rtl/sample_warp_unit_core.sv */
// Throughput: one beat per cycle; the 31-stage root pipes and the CORDIC
// pipe each take a new operand every cycle. The whole pipe freezes only
// while the 2-entry output buffer is full.
// Reset: rst_n clears all side data with its valid bits, both delay lines
// and the buffer pointers and count; math pipes and buffer storage are not.
// Depends on swu_pkg, swu_in_if, swu_out_if, swu_delay, swu_sqrt, swu_cordic.
module sample_warp_unit_core #(
    parameter int FRAC_BITS    = 16,
    parameter int ANGLE_STAGES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    swu_in_if.sink    sample_in,
    swu_out_if.source point_out
);

    localparam int CONV_SH  = 30 - FRAC_BITS;
    localparam int SAT_W    = 58;
    localparam int PROD_W   = 56;
    localparam int CORD_PAD = swu_pkg::SQ_LAT - ANGLE_STAGES - 1;
    localparam swu_pkg::ang_t CONV_RND = swu_pkg::ang_t'(64'sd1 <<< (CONV_SH - 1));
    localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'(2**(swu_pkg::OUT_W-1) - 1);
    localparam logic signed [SAT_W-1:0] OUT_MIN = SAT_W'(-(2**(swu_pkg::OUT_W-1)));
    localparam logic signed [SAT_W-1:0] TRI_RND = SAT_W'(64'sd536870912);
    localparam logic signed [64:0]      MUL_RND = 65'sd536870912;

    function automatic logic [swu_pkg::OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] a);
        logic signed [SAT_W-1:0] t;
        t = a;
        if (t > OUT_MAX)
        begin
            t = OUT_MAX;
        end
        if (t < OUT_MIN)
        begin
            t = OUT_MIN;
        end
        return t[swu_pkg::OUT_W-1:0];
    endfunction

    logic adv;

    // ---------------- front end ----------------
    swu_pkg::side_t s0_reg, s1_reg, s2_reg;
    logic [swu_pkg::RAD_W-1:0] s1_nu_reg;
    logic [swu_pkg::RAD_W-1:0] s1_sq_reg;
    logic [46:0]               s1_zp_reg;
    logic [swu_pkg::RAD_W-1:0] s2_ra_reg;
    logic [swu_pkg::RAD_W-1:0] s2_rb_reg;
    swu_pkg::ang_t             s2_z0_reg;

    swu_pkg::ang_t             f1;
    logic signed [65:0]        f1_sq;
    logic [46:0]               zp;
    logic [46:0]               zp_rnd;
    logic [swu_pkg::RAD_W-1:0] u_q30;
    swu_pkg::ang_t             zf_next;
    swu_pkg::side_t            s1_next;

    assign u_q30  = {1'b0, s0_reg.u, 14'b0};
    assign f1     = {2'b00, s0_reg.u, 15'b0} - swu_pkg::ONE_Q30;
    assign f1_sq  = f1 * f1;
    assign zp     = 47'(s0_reg.v[13:0]) * 47'(swu_pkg::TWO_PI_Q30);
    assign zp_rnd = s1_zp_reg + 47'd32768;

    always_comb
    begin
        case (s0_reg.kind)
            swu_pkg::KIND_HEMI:   zf_next = {2'b00, u_q30};
            swu_pkg::KIND_SPHERE: zf_next = f1;
            default:              zf_next = '0;
        endcase
    end

    // stage 1 side data picks up the linear z
    always_comb
    begin
        s1_next    = s0_reg;
        s1_next.zf = zf_next;
    end

    // side data registers (valid cleared on reset)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (adv)
        begin
            s0_reg.valid  <= sample_in.valid;
            s0_reg.kind   <= sample_in.kind;
            s0_reg.u      <= sample_in.u_sample;
            s0_reg.v      <= sample_in.v_sample;
            s0_reg.zf     <= '0;
            s0_reg.vtx[0] <= {sample_in.vertex0_z, sample_in.vertex0_y, sample_in.vertex0_x};
            s0_reg.vtx[1] <= {sample_in.vertex1_z, sample_in.vertex1_y, sample_in.vertex1_x};
            s0_reg.vtx[2] <= {sample_in.vertex2_z, sample_in.vertex2_y, sample_in.vertex2_x};
            s1_reg        <= s1_next;
            s2_reg        <= s1_reg;
        end
    end

    // radicands and CORDIC start angle
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_nu_reg <= swu_pkg::ONE_U30 - u_q30;
            s1_sq_reg <= f1_sq[60:30];
            s1_zp_reg <= zp;
            case (s1_reg.kind)
                swu_pkg::KIND_HEMI:   s2_ra_reg <= s1_nu_reg;
                swu_pkg::KIND_SPHERE: s2_ra_reg <= swu_pkg::ONE_U30 - s1_sq_reg;
                default:              s2_ra_reg <= {1'b0, s1_reg.u, 14'b0};
            endcase
            s2_rb_reg <= s1_nu_reg;
            s2_z0_reg <= {2'b00, zp_rnd[46:16]};
        end
    end

    // ---------------- root and angle pipes ----------------
    logic [swu_pkg::RAD_W-1:0] root_a, root_b;
    swu_pkg::ang_t             cord_c, cord_s, cos_d, sin_d;
    swu_pkg::side_t            side_d;

    swu_sqrt u_sqrt_a (.clk(clk), .en(adv), .rad(s2_ra_reg), .root(root_a));
    swu_sqrt u_sqrt_b (.clk(clk), .en(adv), .rad(s2_rb_reg), .root(root_b));

    swu_cordic #(.STAGES(ANGLE_STAGES)) u_cordic (
        .clk     (clk),
        .en      (adv),
        .z_in    (s2_z0_reg),
        .quad_in (s2_reg.v[15:14]),
        .cos_out (cord_c),
        .sin_out (cord_s)
    );

    swu_delay #(.WIDTH(2 * swu_pkg::ANG_W), .DEPTH(CORD_PAD)) u_cord_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   ({cord_c, cord_s}),
        .dout  ({cos_d, sin_d})
    );

    swu_delay #(.WIDTH($bits(swu_pkg::side_t)), .DEPTH(swu_pkg::SQ_LAT)) u_side_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .din   (s2_reg),
        .dout  (side_d)
    );

    // ---------------- back end ----------------
    swu_pkg::side_t p0_side_reg, p1_side_reg, p2_side_reg, p3_side_reg;
    logic signed [64:0]        p0_rc_reg, p0_rs_reg;
    logic [46:0]               p0_vs_reg;
    logic [swu_pkg::RAD_W-1:0] p0_ra_reg, p0_rb_reg;
    swu_pkg::ang_t             p1_x_reg, p1_y_reg, p1_z_reg;
    logic [swu_pkg::RAD_W-1:0] p1_b_reg [3];
    swu_pkg::vec_t             p2_pt_reg, p3_pt_reg;
    logic signed [PROD_W-1:0]  p2_prod_reg [3][3];
    logic signed [SAT_W-1:0]   p3_acc_reg [3];

    logic signed [64:0]        rc_rnd, rs_rnd;
    logic [46:0]               vs_rnd;
    logic [swu_pkg::RAD_W-1:0] b1;
    swu_pkg::ang_t             conv_t [3];
    swu_pkg::ang_t             p1_val [3];

    assign rc_rnd    = p0_rc_reg + MUL_RND;
    assign rs_rnd    = p0_rs_reg + MUL_RND;
    assign vs_rnd    = p0_vs_reg + 47'd32768;
    assign b1        = vs_rnd[46:16];
    assign p1_val[0] = p1_x_reg;
    assign p1_val[1] = p1_y_reg;
    assign p1_val[2] = p1_z_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_conv
        assign conv_t[k] = (p1_val[k] + CONV_RND) >>> CONV_SH;
    end

    // side data through the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_side_reg <= '0;
            p1_side_reg <= '0;
            p2_side_reg <= '0;
            p3_side_reg <= '0;
        end
        else if (adv)
        begin
            p0_side_reg <= side_d;
            p1_side_reg <= p0_side_reg;
            p2_side_reg <= p1_side_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    // products, rounding, conversion, triangle weights and sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // P0: radius times cos/sin, v times sqrt(u)
            p0_rc_reg <= $signed({1'b0, root_a}) * cos_d;
            p0_rs_reg <= $signed({1'b0, root_a}) * sin_d;
            p0_vs_reg <= 47'(side_d.v) * 47'(root_a);
            p0_ra_reg <= root_a;
            p0_rb_reg <= root_b;
            // P1: back to Q.30, barycentric weights
            p1_x_reg    <= swu_pkg::ang_t'(rc_rnd >>> 30);
            p1_y_reg    <= swu_pkg::ang_t'(rs_rnd >>> 30);
            p1_z_reg    <= (p0_side_reg.kind == swu_pkg::KIND_COS) ?
                           {2'b00, p0_rb_reg} : p0_side_reg.zf;
            p1_b_reg[0] <= swu_pkg::ONE_U30 - p0_ra_reg;
            p1_b_reg[1] <= b1;
            p1_b_reg[2] <= p0_ra_reg - b1;
            // P2: output format, weight times vertex
            for (int k = 0; k < 3; k++)
            begin
                p2_pt_reg[k] <= sat_out({{(SAT_W - swu_pkg::ANG_W){conv_t[k][swu_pkg::ANG_W-1]}},
                                         conv_t[k]});
                for (int j = 0; j < 3; j++)
                begin
                    p2_prod_reg[k][j] <= $signed({1'b0, p1_b_reg[j]}) *
                                         $signed(p1_side_reg.vtx[j][k]);
                end
            end
            // P3: weighted sums
            p3_pt_reg <= p2_pt_reg;
            for (int k = 0; k < 3; k++)
            begin
                p3_acc_reg[k] <= {{2{p2_prod_reg[k][0][PROD_W-1]}}, p2_prod_reg[k][0]}
                               + {{2{p2_prod_reg[k][1][PROD_W-1]}}, p2_prod_reg[k][1]}
                               + {{2{p2_prod_reg[k][2][PROD_W-1]}}, p2_prod_reg[k][2]};
            end
        end
    end

    // P4: final select by kind
    swu_pkg::vec_t res;
    always_comb
    begin
        if (p3_side_reg.kind == swu_pkg::KIND_TRI)
        begin
            for (int k = 0; k < 3; k++)
            begin
                res[k] = sat_out((p3_acc_reg[k] + TRI_RND) >>> 30);
            end
        end
        else if (p3_side_reg.kind > swu_pkg::KIND_TRI)
        begin
            res = '0;
        end
        else
        begin
            res = p3_pt_reg;
        end
    end

    // ---------------- output buffer ----------------
    swu_pkg::vec_t mem_reg [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign adv   = (cnt_reg != 2'd2);
    assign push  = adv && p3_side_reg.valid;
    assign pop   = point_out.valid && point_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign sample_in.ready = adv;
    assign point_out.valid = (cnt_reg != 2'd0);
    assign point_out.point_x = mem_reg[rd_ptr_reg][0];
    assign point_out.point_y = mem_reg[rd_ptr_reg][1];
    assign point_out.point_z = mem_reg[rd_ptr_reg][2];

    // ---------------- checks ----------------
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready |=> s0_reg.valid)
        else $error("accepted beat did not enter the pipe");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(p3_side_reg) && $stable(s0_reg))
        else $error("pipe moved while frozen");

    a_bad_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        push && p3_side_reg.kind > swu_pkg::KIND_TRI |-> res == '0)
        else $error("unused kind produced a nonzero point");

endmodule

/* sim/tb_sample_warp_unit_core.sv */
// Testbench for sample_warp_unit_core: drives warp requests, predicts each point.
// Depends on swu_pkg, swu_in_if, swu_out_if and the block RTL.
`timescale 1ns / 100ps

module tb_sample_warp_unit_core;

    localparam int FRAC = 16;
    localparam int STAGES = 16;
    localparam longint GAIN = 64'sd652032874;
    localparam longint UNIT = 64'sd1 << 30;
    localparam longint OMAX = 64'sd8388607;
    localparam longint OMIN = -64'sd8388608;

    typedef struct packed {
        logic [swu_pkg::KIND_W-1:0] kind;
        logic [15:0] u;
        logic [15:0] v;
        logic [8:0][23:0] vtx;   // v0x,v0y,v0z,v1x,... at index 0..8
    } warp_req_t;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int errors = 0;
    int sent = 0;
    int got = 0;
    bit calm = 1'b0;

    swu_in_if sample_in ();
    swu_out_if point_out ();

    sample_warp_unit_core #(.FRAC_BITS(FRAC), .ANGLE_STAGES(STAGES)) DUT (
        .clk(clk), .rst_n(rst_n), .sample_in(sample_in), .point_out(point_out)
    );

    always #5 clk = ~clk;

    // mismatch report
    task automatic report(input string what, input logic [23:0] exp_v,
                          input logic [23:0] got_v);
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
        errors++;
    endtask

    // arithmetic shift right with rounding half up
    function automatic longint rnd_shr(input longint x, input int s);
        if (s == 0) return x;
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [23:0] clip24(input longint x);
        if (x > OMAX) x = OMAX;
        if (x < OMIN) x = OMIN;
        return x[23:0];
    endfunction

    // floor root of a Q.30 value, clamped at zero
    function automatic longint root_q30(input longint a);
        longint unsigned n, res, bit_v;
        if (a <= 0) return 0;
        n = longint'(a) << 30;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    // cos/sin of 2*pi*v by CORDIC plus quadrant fold
    function automatic void turn_cos_sin(input logic [15:0] v, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy;
        longint unsigned r;
        r = v[13:0];
        z = longint'((r * 64'd6746518852 + 64'd32768) >> 16);
        x = GAIN;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(swu_pkg::ATAN_Q30[i]);
            end
            else
            begin
                x += dx; y -= dy; z += longint'(swu_pkg::ATAN_Q30[i]);
            end
        end
        case (v[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic point_t warp_point(input warp_req_t q);
        point_t p;
        longint u, v, r, z, c, s, f1, sq, b0, b1, b2, acc;
        u = longint'(q.u) << 14;
        v = longint'(q.v) << 14;
        p = '0;
        r = 0;
        z = 0;
        if (q.kind == swu_pkg::KIND_TRI)
        begin
            sq = root_q30(u);
            b0 = UNIT - sq;
            b1 = rnd_shr(v * sq, 30);
            b2 = UNIT - (b0 + b1);
            for (int k = 0; k < 3; k++)
            begin
                acc = b0 * longint'($signed(q.vtx[k])) + b1 * longint'($signed(q.vtx[3 + k]))
                    + b2 * longint'($signed(q.vtx[6 + k]));
                if (k == 0) p.x = clip24(rnd_shr(acc, 30));
                else if (k == 1) p.y = clip24(rnd_shr(acc, 30));
                else p.z = clip24(rnd_shr(acc, 30));
            end
            return p;
        end
        if (q.kind > swu_pkg::KIND_TRI) return p;
        case (q.kind)
            swu_pkg::KIND_HEMI: begin r = root_q30(UNIT - u); z = u; end
            swu_pkg::KIND_COS: begin r = root_q30(u); z = root_q30(UNIT - u); end
            swu_pkg::KIND_SPHERE:
            begin
                f1 = 2 * u - UNIT;
                r = root_q30(UNIT - ((f1 * f1) >>> 30));
                z = f1;
            end
            default: begin r = root_q30(u); z = 0; end
        endcase
        turn_cos_sin(q.v, c, s);
        p.x = clip24(rnd_shr(rnd_shr(r * c, 30), 30 - FRAC));
        p.y = clip24(rnd_shr(rnd_shr(r * s, 30), 30 - FRAC));
        p.z = clip24(rnd_shr(z, 30 - FRAC));
        return p;
    endfunction

    // scoreboard of pending points
    class point_board;
        point_t pending[$];

        function void note_sample(input warp_req_t q);
            pending.push_back(warp_point(q));
        endfunction

        task check_point(input point_t p);
            point_t e;
            if (pending.size() == 0)
            begin
                report("unexpected point", '0, p.x);
                return;
            end
            e = pending.pop_front();
            if (p.x !== e.x) report("point_x", e.x, p.x);
            if (p.y !== e.y) report("point_y", e.y, p.y);
            if (p.z !== e.z) report("point_z", e.z, p.z);
        endtask
    endclass

    point_board board = new();

    task automatic drive_sample(input warp_req_t q);
        sample_in.kind <= q.kind;
        sample_in.u_sample <= q.u;
        sample_in.v_sample <= q.v;
        sample_in.vertex0_x <= q.vtx[0];
        sample_in.vertex0_y <= q.vtx[1];
        sample_in.vertex0_z <= q.vtx[2];
        sample_in.vertex1_x <= q.vtx[3];
        sample_in.vertex1_y <= q.vtx[4];
        sample_in.vertex1_z <= q.vtx[5];
        sample_in.vertex2_x <= q.vtx[6];
        sample_in.vertex2_y <= q.vtx[7];
        sample_in.vertex2_z <= q.vtx[8];
        sample_in.valid <= 1'b1;
        do @(posedge clk); while (!sample_in.ready);
        board.note_sample(q);
        sent++;
        @(negedge clk);
        // random gap between beats
        if (!calm && $urandom_range(99) < 11)
        begin
            sample_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic warp_req_t rand_req(input bit any_kind);
        warp_req_t q;
        q.kind = any_kind ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        q.u = 16'($urandom);
        q.v = 16'($urandom);
        case ($urandom_range(9))
            0: q.u = 16'hFFFF;
            1: q.u = 16'h0000;
            2: q.v = 16'($urandom_range(3)) << 14;
            default: ;
        endcase
        for (int i = 0; i < 9; i++)
            q.vtx[i] = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed(16'($urandom)) * 8);
        return q;
    endfunction

    // result side: random stalls, check at rising edge
    initial
    begin
        point_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            point_out.ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    always @(posedge clk)
        if (rst_n && point_out.valid && point_out.ready)
        begin
            board.check_point('{point_out.point_x, point_out.point_y, point_out.point_z});
            got++;
        end

    // stimulus
    initial
    begin
        warp_req_t q;
        sample_in.valid = 1'b0;
        sample_in.kind = swu_pkg::KIND_HEMI;
        sample_in.u_sample = '0;
        sample_in.v_sample = '0;
        {sample_in.vertex0_x, sample_in.vertex0_y, sample_in.vertex0_z} = '0;
        {sample_in.vertex1_x, sample_in.vertex1_y, sample_in.vertex1_z} = '0;
        {sample_in.vertex2_x, sample_in.vertex2_y, sample_in.vertex2_z} = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: each kind at the sample extremes, unused kinds, big vertices
        for (int k = 0; k < 8; k++)
        begin
            q.kind = 3'(k);
            q.u = (k % 2) ? 16'hFFFF : 16'h0000;
            q.v = (k % 2) ? 16'h0000 : 16'hFFFF;
            for (int i = 0; i < 9; i++)
                q.vtx[i] = (i % 2) ? 24'h7FFFFF : 24'h800000;
            drive_sample(q);
            q.u = 16'h8000;
            q.v = 16'(k) << 14;
            for (int i = 0; i < 9; i++) q.vtx[i] = (i % 3 == 0) ? 24'hFFFFFF : 24'h010000;
            drive_sample(q);
        end
        q.kind = swu_pkg::KIND_TRI; q.u = 16'hFFFF; q.v = 16'hFFFF;
        for (int i = 0; i < 9; i++) q.vtx[i] = 24'h7FFFFF;
        drive_sample(q);

        // hold off until the pipe drains
        sample_in.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        @(negedge clk);

        // random, with a stretch of back-to-back traffic
        for (int n = 0; n < 1700; n++)
        begin
            calm = (n >= 600 && n < 850);
            drive_sample(rand_req(n % 10 == 0));
        end
        calm = 1'b0;
        sample_in.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d samples and %0d points over all warp kinds, unused kinds included.",
                 sent, got);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/swu_pkg.sv
hw/rtl/swu_in_if.sv
hw/rtl/swu_out_if.sv
hw/rtl/swu_delay.sv
hw/rtl/swu_sqrt.sv
hw/rtl/swu_cordic.sv
hw/rtl/sample_warp_unit_core.sv
sim/tb_sample_warp_unit_core.sv
